// File: rtl/ccv_pkg.sv
`timescale 1ns / 1ps
// Package for the calibrated count-to-voltage block.
// Shared widths, reset values, register indexes, mode codes and state types.
// No dependencies.
package ccv_pkg;

   localparam int NUM_CHANNELS_DEF = 32;
   localparam int COUNT_BITS_DEF   = 17;

   localparam int CHANNEL_W = 5;
   localparam int MODE_W    = 2;
   localparam int SCALE_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_LOW_RESET    = 9817;
   localparam int DEF_HIGH_RESET   = 73181;
   localparam int FULL_SCALE_RESET = 3000;

   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE   = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_CONVERT  = 2'd0,
      MODE_CAL_LOW  = 2'd1,
      MODE_CAL_HIGH = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE,
      ST_PREP,
      ST_SCALE,
      ST_RESP
   } top_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL,
      SC_LOAD,
      SC_DIV,
      SC_DONE
   } scaler_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic valid_bit;
   } store_ctl_type;

endpackage

// File: rtl/calibrated_count_to_voltage_top.sv
`timescale 1ns / 1ps
// Calibrated count-to-voltage top: sequencer, config registers, store and scaler.
// Convert word: READ, PREP, SCALE (scaler multiply, then serial divide), then RESP.
// Calibrate word: READ, CHECK, WRITE, then RESP; a channel beyond the store goes
// from READ straight to RESP. One word at a time; req_ready returns the cycle
// after the result word is taken.
// Synchronous reset restores default counts and full scale and clears all calibration.
module calibrated_count_to_voltage_top import ccv_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [CHANNEL_W-1:0]  req_channel,
   input  logic [COUNT_BITS-1:0] req_raw_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SCALE_W-1:0]    rsp_reading,
   output logic [COUNT_BITS-1:0] rsp_stored_low,
   output logic [COUNT_BITS-1:0] rsp_stored_high,
   output logic                  rsp_channel_valid,
   output logic                  rsp_point_accepted,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [((COUNT_BITS > SCALE_W) ? COUNT_BITS : SCALE_W)-1:0] csr_wdata
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int NEAR_W = COUNT_BITS + 3;

   function automatic logic near_default(input logic [COUNT_BITS-1:0] cnt,
                                         input logic [COUNT_BITS-1:0] dflt);
      logic [COUNT_BITS-1:0] diff;
      logic [NEAR_W-1:0]     diff5;
      diff  = (cnt >= dflt) ? (cnt - dflt) : (dflt - cnt);
      diff5 = NEAR_W'({diff, 2'b00}) + NEAR_W'(diff);
      return diff5 < NEAR_W'(dflt);
   endfunction

   top_state_type          state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [CHANNEL_W-1:0]   chan_ff, chan_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  lo_ff, lo_in;
   logic [COUNT_BITS-1:0]  hi_ff, hi_in;
   logic                   cv_ff, cv_in;
   logic                   acc_ff, acc_in;
   logic [SCALE_W-1:0]     reading_ff, reading_in;

   logic [COUNT_BITS-1:0]  dlow_ff;
   logic [COUNT_BITS-1:0]  dhigh_ff;
   logic [SCALE_W-1:0]     fscale_ff;

   store_ctl_type          st_ctl;
   logic [COUNT_BITS-1:0]  st_rd_low;
   logic [COUNT_BITS-1:0]  st_rd_high;
   logic                   st_rd_valid;

   logic                   in_range;
   logic                   pt_ok;
   logic [COUNT_BITS-1:0]  sel_low;
   logic [COUNT_BITS-1:0]  sel_high;
   logic [COUNT_BITS-1:0]  clamped;
   logic                   span_empty;
   logic [COUNT_BITS-1:0]  prep_num;
   logic [COUNT_BITS-1:0]  prep_den;

   logic                   sc_start;
   logic                   sc_done;
   logic [SCALE_W-1:0]     sc_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         dlow_ff   <= COUNT_BITS'(DEF_LOW_RESET);
         dhigh_ff  <= COUNT_BITS'(DEF_HIGH_RESET);
         fscale_ff <= SCALE_W'(FULL_SCALE_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DEFAULT_LOW:  dlow_ff   <= csr_wdata[COUNT_BITS-1:0];
            REG_DEFAULT_HIGH: dhigh_ff  <= csr_wdata[COUNT_BITS-1:0];
            REG_FULL_SCALE:   fscale_ff <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ccv_cal_store #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_BITS   (COUNT_BITS),
      .IDX_W        (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (st_ctl),
      .rd_idx   (IDX_W'(req_channel)),
      .wr_idx   (IDX_W'(chan_ff)),
      .wr_low   (lo_ff),
      .wr_high  (hi_ff),
      .rd_low   (st_rd_low),
      .rd_high  (st_rd_high),
      .rd_valid (st_rd_valid)
   );

   ccv_scaler #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .num    (prep_num),
      .den    (prep_den),
      .empty  (span_empty),
      .scale  (fscale_ff),
      .done   (sc_done),
      .result (sc_result)
   );

   assign in_range = (32'(chan_ff) < 32'(NUM_CHANNELS));
   assign pt_ok    = near_default(count_ff, (mode_ff == MODE_CAL_LOW) ? dlow_ff : dhigh_ff);

   // cv_ff is already forced low for channels beyond the store
   assign sel_low    = cv_ff ? lo_ff : dlow_ff;
   assign sel_high   = cv_ff ? hi_ff : dhigh_ff;
   assign span_empty = (sel_high <= sel_low);
   assign clamped    = (count_ff < sel_low)  ? sel_low  :
                       (count_ff > sel_high) ? sel_high : count_ff;
   assign prep_num   = clamped - sel_low;
   assign prep_den   = sel_high - sel_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      chan_ff    <= chan_in;
      count_ff   <= count_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      cv_ff      <= cv_in;
      acc_ff     <= acc_in;
      reading_ff <= reading_in;
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      chan_in    = chan_ff;
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      cv_in      = cv_ff;
      acc_in     = acc_ff;
      reading_in = reading_ff;
      st_ctl     = '0;
      sc_start   = 1'b0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in      = req_mode;
               chan_in      = req_channel;
               count_in     = req_raw_count;
               reading_in   = '0;
               acc_in       = 1'b0;
               st_ctl.rd_en = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            lo_in = in_range ? st_rd_low  : '0;
            hi_in = in_range ? st_rd_high : '0;
            cv_in = in_range && st_rd_valid;
            if (mode_ff == MODE_CONVERT) begin
               state_in = ST_PREP;
            end else if (in_range) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_CHECK: begin
            if (mode_ff == MODE_CAL_LOW && pt_ok) begin
               lo_in  = count_ff;
               acc_in = 1'b1;
            end else if (mode_ff == MODE_CAL_HIGH && pt_ok) begin
               hi_in  = count_ff;
               acc_in = 1'b1;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cv_in            = near_default(lo_ff, dlow_ff) && near_default(hi_ff, dhigh_ff);
            st_ctl.wr_en     = 1'b1;
            st_ctl.valid_bit = cv_in;
            state_in         = ST_RESP;
         end
         ST_PREP: begin
            sc_start = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (sc_done) begin
               reading_in = sc_result;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_reading        = reading_ff;
   assign rsp_stored_low     = lo_ff;
   assign rsp_stored_high    = hi_ff;
   assign rsp_channel_valid  = cv_ff;
   assign rsp_point_accepted = acc_ff;

endmodule

// File: rtl/ccv_cal_store.sv
`timescale 1ns / 1ps
// Per-channel calibration store: low/high count memory with written and valid flags.
// Depends on ccv_pkg.
module ccv_cal_store import ccv_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  store_ctl_type         ctl,
   input  logic [IDX_W-1:0]      rd_idx,
   input  logic [IDX_W-1:0]      wr_idx,
   input  logic [COUNT_BITS-1:0] wr_low,
   input  logic [COUNT_BITS-1:0] wr_high,
   output logic [COUNT_BITS-1:0] rd_low,
   output logic [COUNT_BITS-1:0] rd_high,
   output logic                  rd_valid
);

   logic [2*COUNT_BITS-1:0] cal_mem_ff [NUM_CHANNELS];
   logic [2*COUNT_BITS-1:0] rd_word_ff;
   logic [NUM_CHANNELS-1:0] written_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic                    rd_written_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         cal_mem_ff[wr_idx] <= {wr_high, wr_low};
      end
      if (ctl.rd_en) begin
         rd_word_ff <= cal_mem_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         valid_ff      <= '0;
         rd_written_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            written_ff[wr_idx] <= 1'b1;
            valid_ff[wr_idx]   <= ctl.valid_bit;
         end
         if (ctl.rd_en) begin
            rd_written_ff <= written_ff[rd_idx];
            rd_valid_ff   <= valid_ff[rd_idx];
         end
      end
   end

   // unwritten entries read as the cleared value
   assign rd_low   = rd_written_ff ? rd_word_ff[COUNT_BITS-1:0] : '0;
   assign rd_high  = rd_written_ff ? rd_word_ff[2*COUNT_BITS-1:COUNT_BITS] : '0;
   assign rd_valid = rd_valid_ff;

endmodule

// File: rtl/ccv_scaler.sv
`timescale 1ns / 1ps
// Scaling unit: one multiply, then a restoring divide one quotient bit per cycle.
// Depends on ccv_pkg.
module ccv_scaler import ccv_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] num,
   input  logic [COUNT_BITS-1:0] den,
   input  logic                  empty,
   input  logic [SCALE_W-1:0]    scale,
   output logic                  done,
   output logic [SCALE_W-1:0]    result
);

   localparam int PROD_W = COUNT_BITS + SCALE_W;
   localparam int STEP_W = $clog2(SCALE_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SCALE_W - 1);

   scaler_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0]   num_ff, num_in;
   logic [COUNT_BITS-1:0]   den_ff, den_in;
   logic                    empty_ff, empty_in;
   logic [SCALE_W-1:0]      scale_ff, scale_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [SCALE_W-1:0]      quo_ff, quo_in;
   logic [STEP_W-1:0]       step_ff, step_in;

   logic [COUNT_BITS:0]     trial;
   logic [COUNT_BITS:0]     trial_diff;
   logic                    fits;

   // quotient < 2^16 since num <= den, so the top product bits start below den
   assign trial      = {rem_ff, quo_ff[SCALE_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      empty_ff <= empty_in;
      scale_ff <= scale_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      empty_in = empty_ff;
      scale_in = scale_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      done     = 1'b0;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               num_in   = num;
               den_in   = den;
               empty_in = empty;
               scale_in = scale;
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            prod_in  = PROD_W'(num_ff) * PROD_W'(scale_ff);
            state_in = SC_LOAD;
         end
         SC_LOAD: begin
            rem_in   = prod_ff[PROD_W-1:SCALE_W];
            quo_in   = prod_ff[SCALE_W-1:0];
            step_in  = '0;
            state_in = SC_DIV;
         end
         SC_DIV: begin
            rem_in  = fits ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_in  = {quo_ff[SCALE_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: begin
            done     = 1'b1;
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   assign result = empty_ff ? '0 : quo_ff;

endmodule

// File: rtl/ccv_checker.sv
`timescale 1ns / 1ps
// Port-level checks for calibrated_count_to_voltage_top, attached by bind.
// Depends on ccv_pkg and the top level's port list.
module ccv_checker import ccv_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [SCALE_W-1:0]    rsp_reading,
   input logic [COUNT_BITS-1:0] rsp_stored_low,
   input logic [COUNT_BITS-1:0] rsp_stored_high,
   input logic                  rsp_channel_valid,
   input logic                  rsp_point_accepted
);

   // one word in flight: no new request while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while a result word is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready did not drop after an accepted word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_reading)
                                     && $stable(rsp_stored_low)))
      else $error("stalled result word changed");

   a_cal_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_point_accepted) |-> (rsp_reading == '0))
      else $error("calibrate word returned a nonzero reading");

   // a valid channel passed the near-default test, so neither point can be zero
   a_valid_points: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_channel_valid) |->
         (rsp_stored_low != '0 && rsp_stored_high != '0))
      else $error("channel marked valid with a zero calibration point");

endmodule

bind calibrated_count_to_voltage_top ccv_checker #(
   .COUNT_BITS (COUNT_BITS)
) u_ccv_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_reading        (rsp_reading),
   .rsp_stored_low     (rsp_stored_low),
   .rsp_stored_high    (rsp_stored_high),
   .rsp_channel_valid  (rsp_channel_valid),
   .rsp_point_accepted (rsp_point_accepted)
);
